### rtl/sound_angle_tracker_fsm_macros.svh
// Assertion helpers shared by the tracker RTL.
// Both use clk_i and rst_ni of the module they appear in.
`ifndef SOUND_ANGLE_TRACKER_FSM_MACROS_SVH
`define SOUND_ANGLE_TRACKER_FSM_MACROS_SVH

// Same-cycle implication
`define SATF_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define SATF_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/satf_pkg.sv
package satf_pkg;

  // Angles are in 1/64 degree
  localparam int TURN        = 23040;
  localparam int HALF_TURN   = 11520;
  localparam int TILT_CENTER = 5760;
  localparam int TILT_MAX    = 11520;

  // Scan sine table length and its index width
  localparam int SCAN_PERIOD = 200;
  localparam int PHASE_W     = $clog2(SCAN_PERIOD);

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 13;

  typedef enum logic [1:0] {
    ST_IDLE     = 2'd0,
    ST_ACOUSTIC = 2'd1,
    ST_SEARCH   = 2'd2,
    ST_FACE     = 2'd3
  } track_state_e;

  typedef enum logic [1:0] {
    LED_KEEP = 2'd0,
    LED_OFF  = 2'd1,
    LED_RING = 2'd2,
    LED_FACE = 2'd3
  } led_mode_e;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_SMOOTH_GAIN        = 3'd0,
    CFG_LOST_FRAME_LIMIT   = 3'd1,
    CFG_SEARCH_FRAME_LIMIT = 3'd2,
    CFG_STEP_LIMIT         = 3'd3,
    CFG_FACE_MISS_LIMIT    = 3'd4,
    CFG_SCAN_AMPLITUDE     = 3'd5
  } cfg_index_e;

  typedef struct packed {
    logic        mode;
    logic [14:0] sound_heading;
    logic        sound_valid;
    logic        face_seen;
    logic [13:0] tilt_now;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  fsm_state;
    logic        state_changed;
    logic [14:0] aim_angle;
    logic [1:0]  led_mode;
    logic        tilt_drive;
    logic [13:0] tilt_command;
    logic        pan_follow;
    logic        pan_center;
  } out_item_t;

  typedef struct packed {
    logic [8:0]  smooth_gain;
    logic [9:0]  lost_frame_limit;
    logic [9:0]  search_frame_limit;
    logic [10:0] step_limit;
    logic [7:0]  face_miss_limit;
    logic [12:0] scan_amplitude;
  } cfg_t;

  // Scan entry: sign bit over a Q14 magnitude (peak 16384 needs 15 bits)
  typedef logic [15:0] scan_entry_t;
  typedef scan_entry_t scan_rom_t [SCAN_PERIOD];

  // Polynomial sine per entry, evaluated at elaboration
  function automatic scan_rom_t build_scan_rom();
    scan_rom_t rom;
    longint    u;
    longint    quad;
    longint    t;
    longint    t2;
    longint    inner;
    longint    outer;
    longint    s;
    for (int k = 0; k < SCAN_PERIOD; k++) begin
      u    = (longint'(k) * 65536) / SCAN_PERIOD;
      quad = (u >> 14) & 3;
      t    = u & 16383;
      if (quad == 1 || quad == 3) begin
        t = 16384 - t;
      end
      t2     = (t * t) >> 14;
      inner  = 10512 - ((1160 * t2) >> 14);
      outer  = 25736 - ((t2 * inner) >> 14);
      s      = (t * outer) >> 14;
      rom[k] = {(quad >= 2) ? 1'b1 : 1'b0, s[14:0]};
    end
    return rom;
  endfunction

  localparam scan_rom_t SCAN_ROM = build_scan_rom();

endpackage

### rtl/satf_tilt.sv
module satf_tilt (
  input  satf_pkg::cfg_t                 cfg_i,
  input  logic                           search_i,
  input  logic [satf_pkg::PHASE_W-1:0]   phase_i,
  input  logic [13:0]                    tilt_now_i,
  output logic [13:0]                    tilt_cmd_o
);
  import satf_pkg::*;

  localparam logic signed [16:0] CenterS = 17'(TILT_CENTER);
  localparam logic signed [16:0] MaxS    = 17'(TILT_MAX);

  scan_entry_t        entry;
  logic [27:0]        off_full;
  logic [13:0]        off;
  logic signed [16:0] scan_tgt;
  logic signed [16:0] tgt;
  logic signed [16:0] tgt_c;
  logic signed [16:0] now_s;
  logic signed [16:0] lim_s;
  logic signed [16:0] delta;
  logic signed [16:0] delta_c;
  logic signed [16:0] cmd;
  logic signed [16:0] cmd_c;

  // Sweep offset from the sine table
  assign entry    = SCAN_ROM[phase_i];
  assign off_full = 28'(cfg_i.scan_amplitude) * 28'(entry[14:0]);
  assign off      = off_full[27:14];
  assign scan_tgt = entry[15] ? (CenterS - signed'({3'b000, off}))
                              : (CenterS + signed'({3'b000, off}));

  assign now_s = signed'({3'b000, tilt_now_i});
  assign lim_s = signed'({6'b000000, cfg_i.step_limit});

  // Clamp target, limit the step, clamp the command
  always_comb begin
    tgt = search_i ? scan_tgt : CenterS;
    if (tgt < 17'sd0) begin
      tgt_c = 17'sd0;
    end else if (tgt > MaxS) begin
      tgt_c = MaxS;
    end else begin
      tgt_c = tgt;
    end

    delta = tgt_c - now_s;
    if (delta > lim_s) begin
      delta_c = lim_s;
    end else if (delta < -lim_s) begin
      delta_c = -lim_s;
    end else begin
      delta_c = delta;
    end

    cmd = now_s + delta_c;
    if (cmd < 17'sd0) begin
      cmd_c = 17'sd0;
    end else if (cmd > MaxS) begin
      cmd_c = MaxS;
    end else begin
      cmd_c = cmd;
    end
  end

  assign tilt_cmd_o = cmd_c[13:0];

endmodule

### rtl/sound_angle_tracker_fsm.sv
// Channel | direction | handshake              | payload
// in      | input     | in_valid_i / in_ready_o   | in_data_i  (satf_pkg::in_item_t)
// out     | output    | out_valid_o / out_ready_i | out_data_o (satf_pkg::out_item_t)
// cfg     | input     | cfg_valid_i / cfg_ready_o | cfg_index_i, cfg_data_i
//
// One frame per cycle sustained while the output is taken; a result passes through the
// input register, then the result register, and is offered from the result register.
// The tracker state updates as a frame moves into the result register.
// Reset clears the state to idle with zeroed counters and headings, and loads the
// register defaults. cfg is always ready.
// A stalled output holds one result while the input register keeps the next frame.
module sound_angle_tracker_fsm (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  satf_pkg::in_item_t               in_data_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output satf_pkg::out_item_t              out_data_o,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [satf_pkg::CFG_INDEX_W-1:0] cfg_index_i,
  input  logic [satf_pkg::CFG_DATA_W-1:0]  cfg_data_i
);
  import satf_pkg::*;
  `include "sound_angle_tracker_fsm_macros.svh"

  localparam logic [14:0]        TurnU    = 15'(TURN);
  localparam logic signed [16:0] TurnS    = 17'(TURN);
  localparam logic signed [16:0] HalfS    = 17'(HALF_TURN);
  localparam logic [9:0]         CountMax = 10'd1023;
  localparam logic [7:0]         FaceMax  = 8'd255;
  localparam logic [PHASE_W-1:0] PhaseTop = PHASE_W'(SCAN_PERIOD - 1);

  cfg_t cfg_q;

  in_item_t  it_q;
  logic      in_vld_q;
  out_item_t out_q;
  logic      out_vld_q;
  logic      advance;

  track_state_e       state_q, state_d;
  logic [14:0]        smooth_q, smooth_d;
  logic [14:0]        held_q, held_d;
  logic [9:0]         miss_q, miss_d;
  logic [9:0]         scan_q, scan_d;
  logic [PHASE_W-1:0] phase_q, phase_d;
  logic [7:0]         fmiss_q, fmiss_d;

  logic [14:0]        head;
  logic signed [16:0] d_raw;
  logic signed [16:0] d_w;
  logic signed [26:0] prod;
  logic signed [26:0] q_full;
  logic signed [16:0] sum;
  logic [14:0]        smooth_new;

  logic [9:0]         miss_inc;
  logic [9:0]         scan_n;
  logic [PHASE_W-1:0] phase_n;
  logic [7:0]         fmiss_inc;

  led_mode_e   led;
  logic        tdrive;
  logic        follow;
  logic        center;
  logic        aim_start;
  logic [13:0] tilt_cmd;
  out_item_t   res;

  // Configuration writes
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.smooth_gain        <= 9'd77;
      cfg_q.lost_frame_limit   <= 10'd100;
      cfg_q.search_frame_limit <= 10'd250;
      cfg_q.step_limit         <= 11'd192;
      cfg_q.face_miss_limit    <= 8'd15;
      cfg_q.scan_amplitude     <= 13'd1920;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_e'(cfg_index_i))
        CFG_SMOOTH_GAIN:        cfg_q.smooth_gain        <= cfg_data_i[8:0];
        CFG_LOST_FRAME_LIMIT:   cfg_q.lost_frame_limit   <= cfg_data_i[9:0];
        CFG_SEARCH_FRAME_LIMIT: cfg_q.search_frame_limit <= cfg_data_i[9:0];
        CFG_STEP_LIMIT:         cfg_q.step_limit         <= cfg_data_i[10:0];
        CFG_FACE_MISS_LIMIT:    cfg_q.face_miss_limit    <= cfg_data_i[7:0];
        CFG_SCAN_AMPLITUDE:     cfg_q.scan_amplitude     <= cfg_data_i[12:0];
        default: ;
      endcase
    end
  end

  // Handshake: input register feeds result register
  assign advance    = in_vld_q && (!out_vld_q || out_ready_i);
  assign in_ready_o = !in_vld_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_valid_i && in_ready_o) begin
      in_vld_q <= 1'b1;
    end else if (advance) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      it_q <= in_data_i;
    end
  end

  // Heading smoother: wrap the error, scale by alpha, floor, wrap the sum
  assign head  = (it_q.sound_heading >= TurnU) ? (it_q.sound_heading - TurnU)
                                               : it_q.sound_heading;
  assign d_raw = signed'({2'b00, head}) - signed'({2'b00, smooth_q});

  always_comb begin
    if (d_raw > HalfS) begin
      d_w = d_raw - TurnS;
    end else if (d_raw <= -HalfS) begin
      d_w = d_raw + TurnS;
    end else begin
      d_w = d_raw;
    end
  end

  assign prod   = 27'(d_w) * signed'({18'd0, cfg_q.smooth_gain});
  assign q_full = prod >>> 8;
  assign sum    = signed'({2'b00, smooth_q}) + q_full[16:0];

  always_comb begin
    if (sum < 17'sd0) begin
      smooth_new = 15'(sum + TurnS);
    end else if (sum >= TurnS) begin
      smooth_new = 15'(sum - TurnS);
    end else begin
      smooth_new = sum[14:0];
    end
  end

  // Saturating counters and scan phase (tracks scan count mod table length)
  assign miss_inc  = (miss_q != CountMax) ? (miss_q + 10'd1) : miss_q;
  assign fmiss_inc = (fmiss_q != FaceMax) ? (fmiss_q + 8'd1) : fmiss_q;
  assign scan_n    = (scan_q != CountMax) ? (scan_q + 10'd1) : scan_q;

  always_comb begin
    if (scan_q == CountMax) begin
      phase_n = phase_q;
    end else if (phase_q == PhaseTop) begin
      phase_n = '0;
    end else begin
      phase_n = phase_q + 1'b1;
    end
  end

  // Tilt slew toward center or the scan target
  satf_tilt u_tilt (
    .cfg_i      (cfg_q),
    .search_i   (state_q == ST_SEARCH),
    .phase_i    (phase_n),
    .tilt_now_i (it_q.tilt_now),
    .tilt_cmd_o (tilt_cmd)
  );

  // Next state and frame flags
  always_comb begin
    state_d   = state_q;
    smooth_d  = smooth_q;
    held_d    = held_q;
    miss_d    = miss_q;
    scan_d    = scan_q;
    phase_d   = phase_q;
    fmiss_d   = fmiss_q;
    led       = LED_KEEP;
    tdrive    = 1'b0;
    follow    = 1'b0;
    center    = 1'b0;
    aim_start = 1'b0;

    if (!it_q.mode) begin
      case (state_q)
        ST_IDLE: begin
          led = LED_OFF;
          if (it_q.sound_valid) begin
            smooth_d = head;
            held_d   = head;
            miss_d   = '0;
            state_d  = ST_ACOUSTIC;
          end
        end
        ST_ACOUSTIC: begin
          if (it_q.sound_valid) begin
            smooth_d = smooth_new;
            held_d   = smooth_new;
            miss_d   = '0;
            led      = LED_RING;
            follow   = 1'b1;
            tdrive   = 1'b1;
          end else begin
            miss_d = miss_inc;
            if (miss_inc >= cfg_q.lost_frame_limit) begin
              scan_d  = '0;
              phase_d = '0;
              state_d = ST_SEARCH;
            end
          end
        end
        ST_SEARCH: begin
          scan_d    = scan_n;
          phase_d   = phase_n;
          tdrive    = 1'b1;
          led       = LED_RING;
          follow    = 1'b1;
          aim_start = 1'b1;
          if (it_q.sound_valid) begin
            smooth_d = head;
            held_d   = head;
            miss_d   = '0;
            state_d  = ST_ACOUSTIC;
          end else if (scan_n >= cfg_q.search_frame_limit) begin
            center  = 1'b1;
            follow  = 1'b0;
            led     = LED_OFF;
            state_d = ST_IDLE;
          end
        end
        default: ;  // audio is ignored while tracking a face
      endcase
    end else begin
      if (state_q != ST_FACE) begin
        if (it_q.face_seen) begin
          fmiss_d = '0;
          state_d = ST_FACE;
          led     = LED_OFF;
        end
      end else if (it_q.face_seen) begin
        fmiss_d = '0;
        led     = LED_FACE;
      end else begin
        fmiss_d = fmiss_inc;
        if (fmiss_inc >= cfg_q.face_miss_limit) begin
          state_d = ST_ACOUSTIC;
          miss_d  = '0;
        end
      end
    end
  end

  // Result beat
  always_comb begin
    res.fsm_state     = state_d;
    res.state_changed = (state_d != state_q);
    res.aim_angle     = aim_start ? held_q : held_d;
    res.led_mode      = led;
    res.tilt_drive    = tdrive;
    res.tilt_command  = tdrive ? tilt_cmd : 14'd0;
    res.pan_follow    = follow;
    res.pan_center    = center;
  end

  // Tracker state commits as the frame moves on
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      smooth_q <= '0;
      held_q   <= '0;
      miss_q   <= '0;
      scan_q   <= '0;
      phase_q  <= '0;
      fmiss_q  <= '0;
    end else if (advance) begin
      state_q  <= state_d;
      smooth_q <= smooth_d;
      held_q   <= held_d;
      miss_q   <= miss_d;
      scan_q   <= scan_d;
      phase_q  <= phase_d;
      fmiss_q  <= fmiss_d;
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance) begin
      out_vld_q <= 1'b1;
    end else if (out_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

  // Checks
  `SATF_ASSERT_NXT(a_state_matches_beat, advance, state_q == out_q.fsm_state,
                   "state register disagrees with the last result beat")
  `SATF_ASSERT_IMP(a_phase_in_range, 1'b1, phase_q < SCAN_PERIOD,
                   "scan phase beyond table length")
  `SATF_ASSERT_IMP(a_center_means_idle, out_vld_q && out_q.pan_center,
                   out_q.fsm_state == ST_IDLE && out_q.state_changed && !out_q.pan_follow,
                   "pan center without a search timeout")
  `SATF_ASSERT_IMP(a_no_cmd_without_drive, out_vld_q && !out_q.tilt_drive,
                   out_q.tilt_command == 14'd0, "tilt command set without drive")
  `SATF_ASSERT_NXT(a_held_frame_kept, in_vld_q && !advance, in_vld_q && $stable(it_q),
                   "pending frame lost while result side stalled")

endmodule
